@@ hdl/mexp_pkg.sv @@
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types for the modular exponentiation unit: the sequencer states.
// ----------------------------------------------------------------------------
package mexp_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SQUARE,
      ST_MULT,
      ST_FINISH
   } state_type;

endpackage

@@ hdl/modular_exponentiation_unit.sv @@
// ----------------------------------------------------------------------------
// modular_exponentiation_unit
// Base to the exponent modulo the modulus by square-and-multiply, with a
// bit-serial modular multiplier (one multiplier bit per cycle).
// ----------------------------------------------------------------------------
//  channel   ports                                       direction
//  req       req_valid/req_ready, req_base,              in
//            req_exponent, req_modulus
//  rsp       rsp_valid/rsp_ready, rsp_power_result       out
//
//  one item at a time; req_ready is high only while the sequencer is idle
//  the shared shift-and-add multiplier does all the work, one bit of its
//  serial operand per cycle: it reduces the base, then squares for every
//  exponent bit and multiplies once more for each set exponent bit
//  exponent zero or modulus zero go from idle straight to the finish state
//  a finished result waits in the rsp register; the unit holds in its
//  finish state only while an older result is still not taken
//  synchronous active-high reset clears the sequencer and rsp_valid
module modular_exponentiation_unit #(
   parameter int MOD_BITS = 32,
   parameter int EXP_BITS = 63
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [MOD_BITS-1:0] req_base,
   input  logic [EXP_BITS-1:0] req_exponent,
   input  logic [MOD_BITS-1:0] req_modulus,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [MOD_BITS-1:0] rsp_power_result
);

   localparam int W  = MOD_BITS + 2;
   localparam int BW = $clog2(MOD_BITS);
   localparam int EW = $clog2(EXP_BITS);
   localparam logic [BW-1:0] BIT_LAST = BW'(MOD_BITS - 1);
   localparam logic [EW-1:0] EXP_LAST = EW'(EXP_BITS - 1);

   mexp_pkg::state_type state_ff, state_in;

   logic [MOD_BITS-1:0] mod_ff, mod_in;
   logic [MOD_BITS-1:0] base_ff, base_in;
   logic [EXP_BITS-1:0] exp_ff, exp_in;
   logic [MOD_BITS-1:0] r_ff, r_in;
   logic [MOD_BITS-1:0] acc_ff, acc_in;
   logic [MOD_BITS-1:0] opa_ff, opa_in;
   logic [MOD_BITS-1:0] opb_ff, opb_in;
   logic [BW-1:0]       bit_cnt_ff, bit_cnt_in;
   logic [EW-1:0]       exp_cnt_ff, exp_cnt_in;
   logic [MOD_BITS-1:0] result_ff, result_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                accept;
   logic                busy;
   logic                last_step;
   logic                last_exp;
   logic                slot_free;
   logic [W-1:0]        sum;
   logic [W-1:0]        mod_w;
   logic [W-1:0]        mod2_w;
   logic [MOD_BITS-1:0] step;

   assign accept    = req_valid && req_ready;
   assign busy      = (state_ff == mexp_pkg::ST_REDUCE) || (state_ff == mexp_pkg::ST_SQUARE)
                      || (state_ff == mexp_pkg::ST_MULT);
   assign last_step = (bit_cnt_ff == BIT_LAST);
   assign last_exp  = (exp_cnt_ff == EXP_LAST);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // one step of the serial multiplier: acc = (2 acc + bit * a) mod m
   assign mod_w  = {2'b00, mod_ff};
   assign mod2_w = {1'b0, mod_ff, 1'b0};
   assign sum    = {1'b0, acc_ff, 1'b0}
                   + (opb_ff[MOD_BITS-1] ? {2'b00, opa_ff} : {W{1'b0}});

   always_comb begin
      logic [W-1:0] red;
      if (sum >= mod2_w) begin
         red = sum - mod2_w;
      end else if (sum >= mod_w) begin
         red = sum - mod_w;
      end else begin
         red = sum;
      end
      step = red[MOD_BITS-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mexp_pkg::ST_IDLE: begin
            if (accept) begin
               if ((req_exponent == '0) || (req_modulus == '0)) begin
                  state_in = mexp_pkg::ST_FINISH;
               end else begin
                  state_in = mexp_pkg::ST_REDUCE;
               end
            end
         end
         mexp_pkg::ST_REDUCE: begin
            if (last_step) begin
               state_in = mexp_pkg::ST_SQUARE;
            end
         end
         mexp_pkg::ST_SQUARE: begin
            if (last_step) begin
               if (exp_ff[EXP_BITS-1]) begin
                  state_in = mexp_pkg::ST_MULT;
               end else if (last_exp) begin
                  state_in = mexp_pkg::ST_FINISH;
               end
            end
         end
         mexp_pkg::ST_MULT: begin
            if (last_step) begin
               state_in = last_exp ? mexp_pkg::ST_FINISH : mexp_pkg::ST_SQUARE;
            end
         end
         mexp_pkg::ST_FINISH: begin
            if (slot_free) begin
               state_in = mexp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mexp_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      mod_in       = mod_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;
      r_in         = r_ff;
      acc_in       = acc_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      bit_cnt_in   = bit_cnt_ff;
      exp_cnt_in   = exp_cnt_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         mexp_pkg::ST_IDLE: begin
            if (accept) begin
               mod_in     = req_modulus;
               exp_in     = req_exponent;
               acc_in     = '0;
               opa_in     = MOD_BITS'(1);
               opb_in     = req_base;
               bit_cnt_in = '0;
               exp_cnt_in = '0;
               if (req_exponent == '0) begin
                  r_in = MOD_BITS'(1);
               end else if ((req_modulus == '0) || (req_modulus == MOD_BITS'(1))) begin
                  r_in = '0;
               end else begin
                  r_in = MOD_BITS'(1);
               end
            end
         end
         mexp_pkg::ST_FINISH: begin
            if (slot_free) begin
               result_in    = r_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            if (busy) begin
               acc_in     = step;
               opb_in     = {opb_ff[MOD_BITS-2:0], 1'b0};
               bit_cnt_in = bit_cnt_ff + BW'(1);
               if (last_step) begin
                  acc_in     = '0;
                  bit_cnt_in = '0;
                  case (state_ff)
                     mexp_pkg::ST_REDUCE: begin
                        base_in = step;
                        opa_in  = r_ff;
                        opb_in  = r_ff;
                     end
                     mexp_pkg::ST_SQUARE: begin
                        r_in = step;
                        if (exp_ff[EXP_BITS-1]) begin
                           opa_in = base_ff;
                           opb_in = step;
                        end else begin
                           exp_in     = {exp_ff[EXP_BITS-2:0], 1'b0};
                           exp_cnt_in = exp_cnt_ff + EW'(1);
                           opa_in     = step;
                           opb_in     = step;
                        end
                     end
                     default: begin
                        r_in       = step;
                        exp_in     = {exp_ff[EXP_BITS-2:0], 1'b0};
                        exp_cnt_in = exp_cnt_ff + EW'(1);
                        opa_in     = step;
                        opb_in     = step;
                     end
                  endcase
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mexp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mod_ff     <= mod_in;
      base_ff    <= base_in;
      exp_ff     <= exp_in;
      r_ff       <= r_in;
      acc_ff     <= acc_in;
      opa_ff     <= opa_in;
      opb_ff     <= opb_in;
      bit_cnt_ff <= bit_cnt_in;
      exp_cnt_ff <= exp_cnt_in;
      result_ff  <= result_in;
   end

   assign req_ready        = (state_ff == mexp_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = result_ff;

endmodule

@@ verif/modular_exponentiation_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modular_exponentiation_unit_test
// Sends base, exponent and modulus items to the unit and checks that each
// power_result equals the modular power worked out here at 64-bit width.
// A short directed list covers the corner cases, and random items follow.
// Both handshake sides stall at random.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit_test;

   localparam int MOD_W = 32;
   localparam int EXP_W = 63;
   localparam int CLK_HALF = 10;
   localparam int RESET_CYCLES = 9;
   localparam int RANDOM_ITEMS = 125;
   localparam int LONG_HOLD = 5000;
   localparam int IDLE_LIMIT = 50000;
   localparam int DRAIN_CYCLES = 16;
   localparam logic [MOD_W-1:0] MOD_MAX = '1;
   localparam logic [MOD_W-1:0] PRIME_MAX = 32'd4294967291;
   localparam logic [EXP_W-1:0] EXP_MAX = '1;

   typedef enum logic [1:0] {
      RDY_ALWAYS,
      RDY_HALF,
      RDY_SPARSE,
      RDY_TOGGLE
   } ready_mode_type;

   class power_scoreboard_type;
      logic [MOD_W-1:0] expected_q[$];
      int error_count;

      function new();
         error_count = 0;
      endfunction

      function logic [MOD_W-1:0] modular_power(logic [MOD_W-1:0] b, logic [EXP_W-1:0] e,
                                               logic [MOD_W-1:0] m);
         logic [63:0] acc;
         logic [63:0] x;
         logic [63:0] m64;
         if (e == '0) begin
            return 1;
         end
         if (m == '0) begin
            return 0;
         end
         m64 = {32'd0, m};
         x = {32'd0, b} % m64;
         acc = 64'd1 % m64;
         for (int i = EXP_W - 1; i >= 0; i--) begin
            acc = (acc * acc) % m64;
            if (e[i]) begin
               acc = (acc * x) % m64;
            end
         end
         return acc[MOD_W-1:0];
      endfunction

      function void note_request(logic [MOD_W-1:0] b, logic [EXP_W-1:0] e,
                                 logic [MOD_W-1:0] m);
         expected_q.push_back(modular_power(b, e, m));
      endfunction

      function void check_result(logic [MOD_W-1:0] actual);
         logic [MOD_W-1:0] want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected power_result, expected none, actual %h", $time, actual);
            error_count++;
            return;
         end
         want = expected_q.pop_front();
         if (want !== actual) begin
            $display("%0t: power_result mismatch, expected %h, actual %h", $time, want,
                     actual);
            error_count++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [MOD_W-1:0] req_base;
   logic [EXP_W-1:0] req_exponent;
   logic [MOD_W-1:0] req_modulus;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [MOD_W-1:0] rsp_power_result;

   power_scoreboard_type sb = new();
   bit long_hold_req = 1'b0;
   int hold_left = 0;
   int phase_left = 0;
   ready_mode_type ready_mode = RDY_ALWAYS;
   int idle_count = 0;

   modular_exponentiation_unit #(
      .MOD_BITS(MOD_W),
      .EXP_BITS(EXP_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_base(req_base),
      .req_exponent(req_exponent),
      .req_modulus(req_modulus),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_power_result(rsp_power_result)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if (long_hold_req) begin
         hold_left = LONG_HOLD;
         long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (phase_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            phase_left = $urandom_range(8, 64);
         end else begin
            phase_left--;
         end
         case (ready_mode)
            RDY_ALWAYS: rsp_ready <= 1'b1;
            RDY_HALF:   rsp_ready <= 1'($urandom_range(0, 1));
            RDY_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
            default:    rsp_ready <= phase_left[0];
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result(rsp_power_result);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_count <= 0;
      end else if (idle_count >= IDLE_LIMIT) begin
         $display("%0t: timeout, no item moved for %0d cycles", $time, idle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   task automatic send_item(logic [MOD_W-1:0] b, logic [EXP_W-1:0] e, logic [MOD_W-1:0] m);
      @(negedge clock);
      req_valid <= 1'b1;
      req_base <= b;
      req_exponent <= e;
      req_modulus <= m;
      do begin
         @(posedge clock);
      end while (!req_ready);
      sb.note_request(b, e, m);
   endtask

   task automatic pause_sender(int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic wait_all_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic send_random_item();
      logic [MOD_W-1:0] b;
      logic [EXP_W-1:0] e;
      logic [MOD_W-1:0] m;
      int pick;
      b = $urandom;
      case ($urandom_range(0, 3))
         0: b = $urandom_range(0, 15);
         1: b = MOD_MAX - $urandom_range(0, 3);
         default: ;
      endcase
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         m = $urandom_range(1, 16);
      end else if (pick == 1) begin
         m = MOD_MAX - $urandom_range(0, 4);
      end else begin
         m = $urandom;
         if (m == '0) begin
            m = 1;
         end
      end
      e = EXP_W'({$urandom, $urandom});
      pick = $urandom_range(0, 7);
      if (pick == 0) begin
         e = '0;
      end else if (pick < 4) begin
         e = e >> $urandom_range(1, EXP_W - 1);
      end
      send_item(b, e, m);
   endtask

   initial begin
      int sent;
      int burst;
      int gap;
      reset = 1'b1;
      req_valid = 1'b0;
      req_base = '0;
      req_exponent = '0;
      req_modulus = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed corners
      send_item(32'd0, '0, 32'd1);
      send_item(MOD_MAX, '0, MOD_MAX);
      send_item(32'd7, 63'd1, 32'd1);
      send_item(MOD_MAX, EXP_MAX, 32'd1);
      send_item(32'd0, 63'd5, 32'd13);
      send_item(32'd0, EXP_MAX, MOD_MAX);
      send_item(32'd123456, 63'd1, 32'd1000);
      send_item(32'd1000, 63'd3, 32'd1000);
      send_item(MOD_MAX, EXP_MAX, MOD_MAX);
      send_item(MOD_MAX, EXP_MAX, PRIME_MAX);
      send_item(32'd2, 63'(PRIME_MAX - 1), PRIME_MAX);
      send_item(32'd3, 63'd1 << (EXP_W - 1), 32'd2);
      send_item(32'd2, 63'd31, MOD_MAX);
      send_item(32'd65537, 63'd2, MOD_MAX);
      send_item(32'h8000_0000, 63'd2, 32'h8000_0001);
      send_item(32'd5, 63'h2AAA_AAAA_AAAA_AAAA, 32'd97);
      send_item(32'd5, 63'h5555_5555_5555_5555, 32'd97);
      wait_all_results();

      // long receiver hold while items keep coming
      long_hold_req = 1'b1;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 12);
         for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
            send_random_item();
            sent++;
         end
         if (sent == RANDOM_ITEMS / 2) begin
            wait_all_results();
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            pause_sender(gap);
         end
      end

      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/mexp_pkg.sv
hdl/modular_exponentiation_unit.sv
verif/modular_exponentiation_unit_test.sv
